>>> rtl/vpdr_pkg.sv
// Package for the vertex pair dedup and remap block.
// Holds field widths, default sizes and the epoch tag width; used by the top level and testbench.
`timescale 1ns / 1ps

package vpdr_pkg;

    // Port field widths
    localparam int SRC_IDX_W = 16;
    localparam int VTX_IDX_W = 12;

    // Default sizes
    localparam int DEF_MAX_VERTICES = 4096;
    localparam int DEF_TABLE_SLOTS  = 8192;
    localparam int DEF_INDEX_BITS   = 16;

    // Epoch tag stored with each slot; tag zero never marks a live slot
    localparam int EPOCH_W = 8;

endpackage

>>> rtl/vpdr_table.sv
// Slot table memory: one write port, one read port, registered read data.
// Sized by the parameters of vertex_pair_dedup_remap; no package use.
`timescale 1ns / 1ps

module vpdr_table #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 53,
    parameter int AW    = 13
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read the slot array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/vertex_pair_dedup_remap.sv
// Top level of the vertex pair dedup and remap block.
// Uses vpdr_pkg for widths and defaults and vpdr_table for the slot memory.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (i_in_valid / o_in_stall) takes one corner word: a position
//   index, a texture index and a mesh start flag. Output channel (o_out_valid /
//   i_out_stall) returns one result word per corner: the dense vertex index,
//   the first-seen flag, the source indices of a new vertex and overflow.
//   The table is open addressed with linear probing in a single memory with
//   registered read data. Each slot carries an epoch tag; a slot is live only
//   when its tag equals the current epoch, so mesh start just bumps the epoch.
// Timing
//   A corner is accepted in the idle state, which reads its home slot; the
//   check state then tests that slot and reads the next one per probe step.
//   The result lands in the output register and the next corner is accepted
//   while it waits there. An insert is written before the next corner reads.
//   A mesh start that wraps the epoch tag (every 255 meshes) sweeps the table
//   first, then issues the read of the corner's home slot again.
// Reset and stall
//   After reset a clearing pass over every slot tags each one dead;
//   o_in_stall stays high during it. While the receiver stalls, the result
//   word holds and the next finished corner waits in the probe stage.

module vertex_pair_dedup_remap #(
    parameter int MAX_VERTICES = vpdr_pkg::DEF_MAX_VERTICES,
    parameter int TABLE_SLOTS  = vpdr_pkg::DEF_TABLE_SLOTS,
    parameter int INDEX_BITS   = vpdr_pkg::DEF_INDEX_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [vpdr_pkg::SRC_IDX_W-1:0] i_position_index,
    input  logic [vpdr_pkg::SRC_IDX_W-1:0] i_texture_index,
    input  logic                           i_mesh_start,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [vpdr_pkg::VTX_IDX_W-1:0] o_vertex_index,
    output logic                           o_first_seen,
    output logic [vpdr_pkg::SRC_IDX_W-1:0] o_source_position,
    output logic [vpdr_pkg::SRC_IDX_W-1:0] o_source_texture,
    output logic                           o_overflow
);

    localparam int SB  = $clog2(TABLE_SLOTS);
    localparam int KW  = 2 * INDEX_BITS;
    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int EW  = vpdr_pkg::EPOCH_W;
    localparam int MW  = EW + KW + VW;
    localparam int SW  = vpdr_pkg::SRC_IDX_W;
    localparam int OW  = vpdr_pkg::VTX_IDX_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_CHECK
    } t_state;

    t_state         r_state;
    logic [SB-1:0]  r_clr_addr;
    logic           r_pend;
    logic [EW-1:0]  r_epoch;
    logic [CW-1:0]  r_count;
    logic [KW-1:0]  r_key;
    logic [SW-1:0]  r_pos;
    logic [SW-1:0]  r_tex;
    logic [SB-1:0]  r_slot;
    logic [SB-1:0]  r_probe;
    logic           r_out_valid;
    logic [OW-1:0]  r_vidx;
    logic           r_first;
    logic [SW-1:0]  r_spos;
    logic [SW-1:0]  r_stex;
    logic           r_ovf;

    logic [KW-1:0]  w_in_key;
    logic [SB-1:0]  w_home;
    logic [SB-1:0]  w_next_slot;
    logic [MW-1:0]  w_rdata;
    logic [EW-1:0]  w_tag;
    logic [KW-1:0]  w_key;
    logic [VW-1:0]  w_val;
    logic           w_live;
    logic           w_match;
    logic           w_last;
    logic           w_final;
    logic           w_out_free;
    logic           w_room;
    logic           w_accept;
    logic           w_we;
    logic [SB-1:0]  w_waddr;
    logic [MW-1:0]  w_wdata;
    logic [SB-1:0]  w_raddr;

    // Fold the key onto the slot index, then reduce below TABLE_SLOTS
    function automatic logic [SB-1:0] f_home(input logic [KW-1:0] key);
        logic [SB-1:0] h;
        logic [SB:0]   hx;
        h = '0;
        for (int i = 0; i < KW; i++) begin
            h[i % SB] = h[i % SB] ^ key[i];
        end
        hx = {1'b0, h};
        if (hx >= (SB+1)'(TABLE_SLOTS)) begin
            hx = hx - (SB+1)'(TABLE_SLOTS);
        end
        return hx[SB-1:0];
    endfunction

    // Build the key and its home slot
    assign w_in_key = {INDEX_BITS'(i_position_index), INDEX_BITS'(i_texture_index)};
    assign w_home   = f_home(w_in_key);

    // Step to the next slot with wraparound
    assign w_next_slot = (r_slot == SB'(TABLE_SLOTS - 1)) ? '0 : r_slot + 1'b1;

    // Decode the slot word read last cycle
    assign w_tag   = w_rdata[MW-1 -: EW];
    assign w_key   = w_rdata[VW +: KW];
    assign w_val   = w_rdata[VW-1:0];
    assign w_live  = (w_tag == r_epoch);
    assign w_match = w_live && (w_key == r_key);
    assign w_last  = (r_probe == SB'(TABLE_SLOTS - 1));
    assign w_final = !w_live || w_match || w_last;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_room     = (r_count < CW'(MAX_VERTICES));
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);

    // Select memory write: clearing sweep or insert of a new pair
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = (r_state == ST_CHECK) && w_out_free && !w_live && w_room;
            w_waddr = r_slot;
            w_wdata = {r_epoch, r_key, VW'(r_count)};
        end
    end

    // Select memory read address
    always_comb begin
        if (r_state == ST_IDLE) begin
            w_raddr = w_home;
        end else if ((r_state == ST_CHECK) && !w_final) begin
            w_raddr = w_next_slot;
        end else begin
            w_raddr = r_slot;
        end
    end

    vpdr_table #(
        .DEPTH (TABLE_SLOTS),
        .WIDTH (MW),
        .AW    (SB)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sequence clear, accept, probe and result; hold state and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_pend      <= 1'b0;
            r_epoch     <= EW'(1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise the result word when a probe ends, drop it once taken
            if ((r_state == ST_CHECK) && w_final && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == SB'(TABLE_SLOTS - 1)) begin
                        r_state <= r_pend ? ST_ISSUE : ST_IDLE;
                        r_pend  <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_key   <= w_in_key;
                        r_pos   <= i_position_index;
                        r_tex   <= i_texture_index;
                        r_slot  <= w_home;
                        r_probe <= '0;
                        if (i_mesh_start) begin
                            r_count <= '0;
                        end
                        if (i_mesh_start && (r_epoch == '1)) begin
                            r_state    <= ST_CLEAR;
                            r_clr_addr <= '0;
                            r_pend     <= 1'b1;
                            r_epoch    <= EW'(1);
                        end else begin
                            r_state <= ST_CHECK;
                            if (i_mesh_start) begin
                                r_epoch <= r_epoch + 1'b1;
                            end
                        end
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (!w_final) begin
                        r_slot  <= w_next_slot;
                        r_probe <= r_probe + 1'b1;
                    end else if (w_out_free) begin
                        r_state <= ST_IDLE;
                        if (w_match) begin
                            r_vidx  <= OW'(w_val);
                            r_first <= 1'b0;
                            r_spos  <= '0;
                            r_stex  <= '0;
                            r_ovf   <= 1'b0;
                        end else if (!w_live && w_room) begin
                            r_vidx  <= OW'(r_count);
                            r_first <= 1'b1;
                            r_spos  <= r_pos;
                            r_stex  <= r_tex;
                            r_ovf   <= 1'b0;
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_vidx  <= '0;
                            r_first <= 1'b0;
                            r_spos  <= '0;
                            r_stex  <= '0;
                            r_ovf   <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_vertex_index    = r_vidx;
    assign o_first_seen      = r_first;
    assign o_source_position = r_spos;
    assign o_source_texture  = r_stex;
    assign o_overflow        = r_ovf;

    // Vertex count never passes the limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES))
        else $error("vertex count above limit");

    // The live epoch is never the dead tag
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("epoch reached dead tag");

    // A result is never both a new vertex and an overflow
    a_first_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_first && r_ovf))
        else $error("first_seen and overflow together");

    // A new vertex always advances the count by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && (r_state == ST_CHECK)) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert without count step");

    // A stalled result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_vidx)))
        else $error("result word lost under stall");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for vertex_pair_dedup_remap: drives corner words, predicts the
// dense vertex index of each one and checks every result word in order.
// Depends on rtl/vpdr_pkg.sv and rtl/vertex_pair_dedup_remap.sv.
`timescale 1ns / 1ps

module testbench;

    localparam int SRC_W     = vpdr_pkg::SRC_IDX_W;
    localparam int VTX_W     = vpdr_pkg::VTX_IDX_W;
    localparam int MAX_VERTS = vpdr_pkg::DEF_MAX_VERTICES;
    localparam int SLOTS     = vpdr_pkg::DEF_TABLE_SLOTS;
    localparam int KEY_BITS  = vpdr_pkg::DEF_INDEX_BITS;
    localparam bit [63:0] KEY_MASK = (64'd1 << KEY_BITS) - 64'd1;

    typedef struct packed {
        logic [VTX_W-1:0] vertex_index;
        logic             first_seen;
        logic [SRC_W-1:0] source_position;
        logic [SRC_W-1:0] source_texture;
        logic             overflow;
    } t_vertex_word;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [SRC_W-1:0] i_position_index;
    logic [SRC_W-1:0] i_texture_index;
    logic             i_mesh_start;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [VTX_W-1:0] o_vertex_index;
    logic             o_first_seen;
    logic [SRC_W-1:0] o_source_position;
    logic [SRC_W-1:0] o_source_texture;
    logic             o_overflow;

    // Predictor state: pair key -> dense vertex index of the current mesh
    int unsigned  pair_to_vertex [bit [63:0]];
    int unsigned  vertices_in_mesh;
    t_vertex_word pending_vertices [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatch_count;

    vertex_pair_dedup_remap u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_position_index  (i_position_index),
        .i_texture_index   (i_texture_index),
        .i_mesh_start      (i_mesh_start),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_vertex_index    (o_vertex_index),
        .o_first_seen      (o_first_seen),
        .o_source_position (o_source_position),
        .o_source_texture  (o_source_texture),
        .o_overflow        (o_overflow)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Remap one corner: look the pair up, append it if new, flag a full table
    function automatic t_vertex_word remap_corner(logic [SRC_W-1:0] pos, logic [SRC_W-1:0] tex,
                                                  logic start);
        t_vertex_word w;
        bit [63:0]    key;
        key = ((64'(pos) & KEY_MASK) << KEY_BITS) | (64'(tex) & KEY_MASK);
        w = '0;
        if (start) begin
            pair_to_vertex.delete();
            vertices_in_mesh = 0;
        end
        if (pair_to_vertex.exists(key)) begin
            w.vertex_index = VTX_W'(pair_to_vertex[key]);
        end else if (vertices_in_mesh >= MAX_VERTS || pair_to_vertex.num() >= SLOTS) begin
            // linear probing finds a free slot unless every slot is taken
            w.overflow = 1'b1;
        end else begin
            pair_to_vertex[key] = vertices_in_mesh;
            w.vertex_index    = VTX_W'(vertices_in_mesh);
            w.first_seen      = 1'b1;
            w.source_position = pos;
            w.source_texture  = tex;
            vertices_in_mesh++;
        end
        return w;
    endfunction

    // Send one corner word; idle at random first, hold it until accepted
    task automatic send_corner(input logic [SRC_W-1:0] pos, input logic [SRC_W-1:0] tex,
                               input logic start);
        t_vertex_word want_word;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_position_index <= pos;
        i_texture_index  <= tex;
        i_mesh_start     <= start;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        want_word = remap_corner(pos, tex, start);
        pending_vertices.insert(pending_vertices.size(), want_word);
    endtask

    task automatic park_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (pending_vertices.size() != 0) @(posedge i_clk);
    endtask

    // Edge values, pairs that differ in one field only, restarts on known pairs
    task automatic test_directed_pairs();
        send_corner(16'h0000, 16'h0000, 1'b0);
        send_corner(16'h0000, 16'h0000, 1'b0);
        send_corner(16'hFFFF, 16'hFFFF, 1'b0);
        send_corner(16'h0000, 16'hFFFF, 1'b0);
        send_corner(16'hFFFF, 16'h0000, 1'b0);
        send_corner(16'h0000, 16'h0000, 1'b0);
        send_corner(16'h0001, 16'h0000, 1'b0);
        send_corner(16'h0000, 16'h0001, 1'b0);
        send_corner(16'h8000, 16'h0001, 1'b0);
        send_corner(16'h0001, 16'h8000, 1'b0);
        send_corner(16'hFFFF, 16'hFFFF, 1'b1);
        send_corner(16'h0000, 16'h0000, 1'b0);
        send_corner(16'hFFFF, 16'hFFFF, 1'b0);
        send_corner(16'h1234, 16'h5678, 1'b1);
        send_corner(16'h1234, 16'h5678, 1'b1);
        send_corner(16'hAAAA, 16'h5555, 1'b0);
        send_corner(16'h5555, 16'hAAAA, 1'b0);
        send_corner(16'hAAAA, 16'h5555, 1'b0);
        send_corner(16'h1234, 16'h5678, 1'b0);
    endtask

    // Many short meshes over one small pool, so restarts pile up past the tag wrap
    task automatic test_mesh_epochs(input int unsigned mesh_total);
        logic [SRC_W-1:0] pool_pos [6];
        logic [SRC_W-1:0] pool_tex [6];
        int unsigned      m, k, len, pick;
        for (k = 0; k < 6; k++) begin
            pool_pos[k] = SRC_W'($urandom);
            pool_tex[k] = SRC_W'($urandom);
        end
        // share a position between two pairs
        pool_pos[5] = pool_pos[0];
        for (m = 0; m < mesh_total; m++) begin
            len = $urandom_range(1, 2);
            for (k = 0; k < len; k++) begin
                pick = $urandom_range(5);
                send_corner(pool_pos[pick], pool_tex[pick], k == 0);
            end
        end
    endtask

    // Well-formed meshes with random content, plus fresh pairs and stray restarts
    task automatic test_random_meshes(input int unsigned corner_total);
        logic [SRC_W-1:0] pool_pos [$];
        logic [SRC_W-1:0] pool_tex [$];
        logic [SRC_W-1:0] pos, tex;
        logic             start;
        int unsigned      sent, k, pool_len, mesh_len, roll, pick;
        sent = 0;
        while (sent < corner_total) begin
            pool_pos.delete();
            pool_tex.delete();
            pool_len = $urandom_range(1, 16);
            for (k = 0; k < pool_len; k++) begin
                pos = SRC_W'($urandom);
                tex = SRC_W'($urandom);
                // reuse one index of an earlier pair now and then
                if (k > 0 && $urandom_range(3) == 0) pos = pool_pos[$urandom_range(k - 1)];
                else if (k > 0 && $urandom_range(3) == 0) tex = pool_tex[$urandom_range(k - 1)];
                pool_pos.insert(pool_pos.size(), pos);
                pool_tex.insert(pool_tex.size(), tex);
            end
            mesh_len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
            for (k = 0; k < mesh_len; k++) begin
                start = (k == 0) && ($urandom_range(9) != 0);
                roll  = $urandom_range(99);
                if (roll < 8) begin
                    pos = SRC_W'($urandom);
                    tex = SRC_W'($urandom);
                end else begin
                    pick = $urandom_range(pool_len - 1);
                    pos  = pool_pos[pick];
                    tex  = pool_tex[pick];
                end
                if (roll >= 96) start = 1'b1;
                send_corner(pos, tex, start);
                sent++;
            end
        end
    endtask

    // Grow one mesh to many vertices with repeats mixed in, then restart
    task automatic test_large_mesh(input int unsigned vertex_total);
        logic [SRC_W-1:0] seen_pos [$];
        logic [SRC_W-1:0] seen_tex [$];
        logic [SRC_W-1:0] pos, tex;
        int unsigned      n, pick;
        for (n = 0; n < vertex_total; n++) begin
            // odd multiplier keeps every position distinct
            pos = SRC_W'(n * 40503);
            tex = SRC_W'($urandom);
            send_corner(pos, tex, n == 0);
            seen_pos.insert(seen_pos.size(), pos);
            seen_tex.insert(seen_tex.size(), tex);
            if ($urandom_range(9) == 0) begin
                pick = $urandom_range(n);
                send_corner(seen_pos[pick], seen_tex[pick], 1'b0);
            end
        end
        send_corner(seen_pos[vertex_total - 1], seen_tex[vertex_total - 1], 1'b0);
        send_corner(seen_pos[0], seen_tex[0], 1'b0);
        send_corner(SRC_W'(vertex_total * 40503), 16'h0000, 1'b1);
        send_corner(seen_pos[0], seen_tex[0], 1'b0);
    endtask

    // Randomize receiver stall at the falling edge
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check each accepted result word against the oldest prediction
    always @(posedge i_clk) begin : check_words
        t_vertex_word want;
        t_vertex_word got;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got = {o_vertex_index, o_first_seen, o_source_position, o_source_texture,
                   o_overflow};
            if (pending_vertices.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result word with no corner pending: idx=%0d first=%0b",
                             $realtime, got.vertex_index, got.first_seen);
            end else begin
                want = pending_vertices.pop_front();
                if (got.vertex_index !== want.vertex_index ||
                    got.first_seen !== want.first_seen ||
                    got.source_position !== want.source_position ||
                    got.source_texture !== want.source_texture ||
                    got.overflow !== want.overflow) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch: expected idx=%0d first=%0b pos=%h tex=%h ",
                                  "ovf=%0b, got idx=%0d first=%0b pos=%h tex=%h ovf=%0b"},
                                 $realtime, want.vertex_index, want.first_seen,
                                 want.source_position, want.source_texture, want.overflow,
                                 got.vertex_index, got.first_seen, got.source_position,
                                 got.source_texture, got.overflow);
                end
            end
        end
    end

    // Run limit, well past the slowest correct run
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_position_index = '0;
        i_texture_index  = '0;
        i_mesh_start     = 1'b0;
        i_out_stall      = 1'b0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        mismatch_count   = 0;
        vertices_in_mesh = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 77;
        test_directed_pairs();
        test_mesh_epochs(270);

        // hold off input until every result word is back
        park_input();
        wait_results_drained();

        send_idle_pct = 77;
        recv_idle_pct = 24;
        test_random_meshes(480);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_meshes(480);
        test_large_mesh(500);

        park_input();
        wait_results_drained();
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
